### rtl/rhct_pkg.sv
`timescale 1ns / 1ps

package rhct_pkg;

	// field widths of the stream beats
	localparam int ID_FIELD_W = 16;
	localparam int WEIGHT_FIELD_W = 32;
	localparam int COUNT_W = 8;
	localparam int RANK_W = 6;
	localparam int LIMIT_W = 7;

	// packed beat widths (tdata in whole bytes)
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	// report limits
	localparam int MAX_REPORT = 64;
	localparam int LIMIT_RESET = 30;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// parameter defaults
	localparam int DEPTH_DEF = 64;
	localparam int ID_BITS_DEF = 16;
	localparam int WEIGHT_BITS_DEF = 32;

	// command broadcast to every cell
	typedef enum logic [2:0] {
		OP_NONE,
		OP_MATCH,
		OP_BUMP,
		OP_INSERT,
		OP_MOVE,
		OP_ROTATE
	} cell_op_t;

	// status a cell shows its neighbors and the controller
	typedef struct packed {
		logic valid;
		logic hit;
		logic beats;
		logic moving;
		logic swap;
	} cell_flag_t;

endpackage

### rtl/rhct_cell.sv
`timescale 1ns / 1ps

module rhct_cell import rhct_pkg::*; #(
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_op_t               op,
	input  logic                   head,
	input  logic                   tail,
	input  logic [ID_BITS-1:0]     key_id,
	input  logic [WEIGHT_BITS-1:0] key_wt,
	input  cell_flag_t             prev_flag,
	input  logic [ID_BITS-1:0]     prev_id,
	input  logic [COUNT_W-1:0]     prev_cnt,
	input  logic [WEIGHT_BITS-1:0] prev_wt,
	input  cell_flag_t             next_flag,
	input  logic [ID_BITS-1:0]     next_id,
	input  logic [COUNT_W-1:0]     next_cnt,
	input  logic [WEIGHT_BITS-1:0] next_wt,
	input  logic [ID_BITS-1:0]     first_id,
	input  logic [COUNT_W-1:0]     first_cnt,
	input  logic [WEIGHT_BITS-1:0] first_wt,
	output cell_flag_t             flag,
	output logic [ID_BITS-1:0]     cur_id,
	output logic [COUNT_W-1:0]     cur_cnt,
	output logic [WEIGHT_BITS-1:0] cur_wt
);

	logic                   vld_q;
	logic                   mv_q;
	logic                   hit_q;
	logic [ID_BITS-1:0]     id_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [WEIGHT_BITS-1:0] wt_q;

	logic beats_new;
	logic prev_wins;
	logic swap;
	logic ins_here;

	// local compares: against the new entry (count 1) and against the left neighbor
	always_comb begin
		beats_new = vld_q && ((cnt_q > COUNT_W'(1)) ||
			((cnt_q == COUNT_W'(1)) && (wt_q > key_wt)));
		prev_wins = (prev_cnt > cnt_q) || ((prev_cnt == cnt_q) && (prev_wt > wt_q));
		swap = mv_q && !head && !prev_wins;
		ins_here = head || prev_flag.beats;
	end

	assign flag = '{valid: vld_q, hit: hit_q, beats: beats_new, moving: mv_q, swap: swap};
	assign cur_id = id_q;
	assign cur_cnt = cnt_q;
	assign cur_wt = wt_q;

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			mv_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			unique case (op)
				OP_MATCH: hit_q <= vld_q && (id_q == key_id);
				OP_BUMP: begin
					hit_q <= 1'b0;
					if (hit_q) mv_q <= 1'b1;
				end
				OP_INSERT: begin
					hit_q <= 1'b0;
					if (!beats_new) vld_q <= ins_here ? 1'b1 : prev_flag.valid;
				end
				// the moving mark follows the entry one place left per cycle
				OP_MOVE: mv_q <= next_flag.swap;
				default: ;
			endcase
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		unique case (op)
			OP_BUMP: begin
				if (hit_q && (cnt_q != COUNT_MAX)) cnt_q <= cnt_q + COUNT_W'(1);
			end
			OP_INSERT: begin
				if (!beats_new) begin
					if (ins_here) begin
						id_q <= key_id;
						cnt_q <= COUNT_W'(1);
						wt_q <= key_wt;
					end else begin
						id_q <= prev_id;
						cnt_q <= prev_cnt;
						wt_q <= prev_wt;
					end
				end
			end
			OP_MOVE: begin
				if (next_flag.swap) begin
					id_q <= next_id;
					cnt_q <= next_cnt;
					wt_q <= next_wt;
				end else if (swap) begin
					id_q <= prev_id;
					cnt_q <= prev_cnt;
					wt_q <= prev_wt;
				end
			end
			// report: valid entries rotate toward the head, the head wraps to the tail
			OP_ROTATE: begin
				if (vld_q) begin
					if (tail) begin
						id_q <= first_id;
						cnt_q <= first_cnt;
						wt_q <= first_wt;
					end else begin
						id_q <= next_id;
						cnt_q <= next_cnt;
						wt_q <= next_wt;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/rhct_ctrl.sv
`timescale 1ns / 1ps

module rhct_ctrl import rhct_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int OCC_W = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_action,
	input  logic [ID_BITS-1:0]        in_id,
	input  logic [WEIGHT_BITS-1:0]    in_wt,
	input  logic                      cfg_we,
	input  logic [LIMIT_W-1:0]        cfg_data,
	input  logic                      hit_any,
	input  logic                      moving_any,
	input  logic [ID_BITS-1:0]        head_id,
	input  logic [COUNT_W-1:0]        head_cnt,
	output cell_op_t                  op,
	output logic [ID_BITS-1:0]        key_id,
	output logic [WEIGHT_BITS-1:0]    key_wt,
	output logic [OCC_W-1:0]          occ,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ID_FIELD_W-1:0]     out_id,
	output logic [RANK_W-1:0]         out_rank,
	output logic [COUNT_W-1:0]        out_cnt,
	output logic                      out_last,
	output logic                      out_empty,
	output logic                      out_ovf
);

	localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MATCH  = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_MOVE   = 3'd3;
	localparam logic [2:0] ST_REPORT = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	logic [2:0]             st_q;
	logic [OCC_W-1:0]       occ_q;
	logic                   drop_q;
	logic [LIMIT_W-1:0]     lim_q;
	logic [LIMIT_W-1:0]     k_q;
	logic [LIMIT_W-1:0]     n_q;
	logic [OCC_W-1:0]       rot_q;
	logic [ID_BITS-1:0]     key_id_q;
	logic [WEIGHT_BITS-1:0] key_wt_q;
	logic                   ovld_q;
	logic [ID_FIELD_W-1:0]  o_id_q;
	logic [RANK_W-1:0]      o_rank_q;
	logic [COUNT_W-1:0]     o_cnt_q;
	logic                   o_last_q;
	logic                   o_empty_q;
	logic                   o_ovf_q;

	logic               full;
	logic               slot_free;
	logic               emit;
	logic               adv;
	logic               load_empty;
	logic [LIMIT_W-1:0] lim_eff;
	logic [CMP_W-1:0]   occ_x;
	logic [CMP_W-1:0]   lim_x;
	logic [LIMIT_W-1:0] n_new;

	// limit clamp and entries per report
	always_comb begin
		if (lim_q == '0) lim_eff = LIMIT_W'(1);
		else if (lim_q > LIMIT_W'(MAX_REPORT)) lim_eff = LIMIT_W'(MAX_REPORT);
		else lim_eff = lim_q;
		occ_x = CMP_W'(occ_q);
		lim_x = CMP_W'(lim_eff);
		n_new = LIMIT_W'((occ_x < lim_x) ? occ_x : lim_x);
	end

	// report stepping: a rotation per cycle, stalled only while a beat is owed
	always_comb begin
		full = (occ_q == OCC_W'(DEPTH));
		slot_free = !ovld_q || out_ready;
		emit = (st_q == ST_REPORT) && (k_q < n_q) && slot_free;
		adv = (st_q == ST_REPORT) && (emit || (k_q >= n_q));
		load_empty = (st_q == ST_EMPTY) && slot_free;
	end

	// command to the cells
	always_comb begin
		op = OP_NONE;
		unique case (st_q)
			ST_MATCH: op = OP_MATCH;
			ST_DECIDE: begin
				if (hit_any) op = OP_BUMP;
				else if (!full) op = OP_INSERT;
			end
			ST_MOVE: op = OP_MOVE;
			ST_REPORT: begin
				if (adv) op = OP_ROTATE;
			end
			default: op = OP_NONE;
		endcase
	end

	assign in_ready = (st_q == ST_IDLE);
	assign key_id = key_id_q;
	assign key_wt = key_wt_q;
	assign occ = occ_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			occ_q <= '0;
			drop_q <= 1'b0;
			lim_q <= LIMIT_W'(LIMIT_RESET);
			k_q <= '0;
			n_q <= '0;
			rot_q <= '0;
		end else begin
			if (cfg_we) lim_q <= cfg_data;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						k_q <= '0;
						rot_q <= '0;
						n_q <= n_new;
						if (!in_action) st_q <= ST_MATCH;
						else if (occ_q == '0) st_q <= ST_EMPTY;
						else st_q <= ST_REPORT;
					end
				end
				ST_MATCH: st_q <= ST_DECIDE;
				ST_DECIDE: begin
					if (hit_any) begin
						st_q <= ST_MOVE;
					end else if (full) begin
						drop_q <= 1'b1;
						st_q <= ST_IDLE;
					end else begin
						occ_q <= occ_q + OCC_W'(1);
						st_q <= ST_IDLE;
					end
				end
				ST_MOVE: begin
					if (!moving_any) st_q <= ST_IDLE;
				end
				ST_REPORT: begin
					if (adv) begin
						rot_q <= rot_q + OCC_W'(1);
						if (emit) k_q <= k_q + LIMIT_W'(1);
						if (rot_q == occ_q - OCC_W'(1)) st_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (slot_free) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// input key capture
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_id_q <= in_id;
			key_wt_q <= in_wt;
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (emit || load_empty) ovld_q <= 1'b1;
		else if (out_ready) ovld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_id_q <= ID_FIELD_W'(head_id);
			o_rank_q <= k_q[RANK_W-1:0];
			o_cnt_q <= head_cnt;
			o_last_q <= (k_q + LIMIT_W'(1)) == n_q;
			o_empty_q <= 1'b0;
			o_ovf_q <= drop_q;
		end else if (load_empty) begin
			o_id_q <= '0;
			o_rank_q <= '0;
			o_cnt_q <= '0;
			o_last_q <= 1'b0;
			o_empty_q <= 1'b1;
			o_ovf_q <= 1'b0;
		end
	end

	assign out_valid = ovld_q;
	assign out_id = o_id_q;
	assign out_rank = o_rank_q;
	assign out_cnt = o_cnt_q;
	assign out_last = o_last_q;
	assign out_empty = o_empty_q;
	assign out_ovf = o_ovf_q;

endmodule

### rtl/ranked_hit_count_table_top.sv
`timescale 1ns / 1ps
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tdata: item_id, item_weight; tuser: action
// m_axis    | out | m_axis_tvalid/tready   | tdata: ranked_id, rank, hit_count; tlast: is_last;
//           |     |                        | tuser: is_empty, overflowed
// cfg       | in  | cfg_we (no wait)       | cfg_data: report_limit
//
// A hit on a new id passes accept, match and insert; a hit on a stored id passes accept,
// match and bump, then climbs place by place along the neighbor swap chain.
// A report rotates the cell chain once through all occupied entries, stalling only while
// a ranked beat waits on the output; an empty report sends a single empty beat.
// arst_n clears the valid bits, counters and flags; the limit returns to 30.

module ranked_hit_count_table_top import rhct_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // item_id[15:0], item_weight[47:16]
	input  logic [0:0]           s_axis_tuser,  // action[0]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // ranked_id[15:0], rank[21:16],
	                                            // hit_count[29:22], zero[31:30]
	output logic                 m_axis_tlast,  // is_last
	output logic [M_TUSER_W-1:0] m_axis_tuser,  // is_empty[0], overflowed[1]
	input  logic                 cfg_we,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	localparam int OCC_W = $clog2(DEPTH + 1);

	cell_op_t               op;
	logic [ID_BITS-1:0]     key_id;
	logic [WEIGHT_BITS-1:0] key_wt;
	logic [OCC_W-1:0]       occ;
	logic                   hit_any;
	logic                   moving_any;

	cell_flag_t             c_flag [DEPTH];
	logic [ID_BITS-1:0]     c_id [DEPTH];
	logic [COUNT_W-1:0]     c_cnt [DEPTH];
	logic [WEIGHT_BITS-1:0] c_wt [DEPTH];
	logic [DEPTH-1:0]       hit_vec;
	logic [DEPTH-1:0]       mv_vec;
	logic [DEPTH-1:0]       vld_vec;

	logic [ID_FIELD_W-1:0] out_id;
	logic [RANK_W-1:0]     out_rank;
	logic [COUNT_W-1:0]    out_cnt;
	logic                  out_empty;
	logic                  out_ovf;

	// chain of cells, each wired to its neighbors and to the head
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_flag_t             p_flag;
		logic [ID_BITS-1:0]     p_id;
		logic [COUNT_W-1:0]     p_cnt;
		logic [WEIGHT_BITS-1:0] p_wt;
		cell_flag_t             n_flag;
		logic [ID_BITS-1:0]     n_id;
		logic [COUNT_W-1:0]     n_cnt;
		logic [WEIGHT_BITS-1:0] n_wt;

		if (g == 0) begin : g_head
			assign p_flag = '0;
			assign p_id = '0;
			assign p_cnt = '0;
			assign p_wt = '0;
		end else begin : g_mid
			assign p_flag = c_flag[g-1];
			assign p_id = c_id[g-1];
			assign p_cnt = c_cnt[g-1];
			assign p_wt = c_wt[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign n_flag = '0;
			assign n_id = '0;
			assign n_cnt = '0;
			assign n_wt = '0;
		end else begin : g_link
			assign n_flag = c_flag[g+1];
			assign n_id = c_id[g+1];
			assign n_cnt = c_cnt[g+1];
			assign n_wt = c_wt[g+1];
		end

		rhct_cell #(
			.ID_BITS(ID_BITS),
			.WEIGHT_BITS(WEIGHT_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.op(op),
			.head(g == 0),
			.tail(occ == OCC_W'(g + 1)),
			.key_id(key_id),
			.key_wt(key_wt),
			.prev_flag(p_flag),
			.prev_id(p_id),
			.prev_cnt(p_cnt),
			.prev_wt(p_wt),
			.next_flag(n_flag),
			.next_id(n_id),
			.next_cnt(n_cnt),
			.next_wt(n_wt),
			.first_id(c_id[0]),
			.first_cnt(c_cnt[0]),
			.first_wt(c_wt[0]),
			.flag(c_flag[g]),
			.cur_id(c_id[g]),
			.cur_cnt(c_cnt[g]),
			.cur_wt(c_wt[g])
		);

		assign hit_vec[g] = c_flag[g].hit;
		assign mv_vec[g] = c_flag[g].moving;
		assign vld_vec[g] = c_flag[g].valid;
	end

	assign hit_any = |hit_vec;
	assign moving_any = |mv_vec;

	rhct_ctrl #(
		.DEPTH(DEPTH),
		.ID_BITS(ID_BITS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.OCC_W(OCC_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_action(s_axis_tuser[0]),
		.in_id(ID_BITS'(s_axis_tdata[ID_FIELD_W-1:0])),
		.in_wt(WEIGHT_BITS'(s_axis_tdata[ID_FIELD_W +: WEIGHT_FIELD_W])),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.hit_any(hit_any),
		.moving_any(moving_any),
		.head_id(c_id[0]),
		.head_cnt(c_cnt[0]),
		.op(op),
		.key_id(key_id),
		.key_wt(key_wt),
		.occ(occ),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_id(out_id),
		.out_rank(out_rank),
		.out_cnt(out_cnt),
		.out_last(m_axis_tlast),
		.out_empty(out_empty),
		.out_ovf(out_ovf)
	);

	// beat packing
	assign m_axis_tdata = M_TDATA_W'({out_cnt, out_rank, out_id});
	assign m_axis_tuser = {out_ovf, out_empty};

`ifndef SYNTHESIS
	// ids are unique, so a lookup hits one cell at most
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("more than one cell matched the key");

	// only the bumped entry climbs
	a_one_mover: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(mv_vec))
		else $error("more than one entry moving");

	// valid cells and the fill count agree
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(occ))
		else $error("valid cells disagree with fill count");

	// no new beat is taken while an entry still climbs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		moving_any |-> !s_axis_tready)
		else $error("input ready while entry moving");
`endif

endmodule

### tb/ranked_hit_count_table_top_tb.sv
`timescale 1ns / 1ps

module ranked_hit_count_table_top_tb;
	import rhct_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic ACT_HIT = 1'b0;
	localparam logic ACT_REPORT = 1'b1;
	// a stored-id hit climbs at most DEPTH - 1 places; give it some margin
	localparam int SETTLE_CYCLES = DEPTH + 20;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int POOL_SIZE = 48;

	// one expected output beat
	typedef struct packed {
		logic [ID_FIELD_W-1:0] ranked_id;
		logic [RANK_W-1:0]     rank;
		logic [COUNT_W-1:0]    hit_count;
		logic                  is_last;
		logic                  is_empty;
		logic                  overflowed;
	} rank_beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;   // item_id[15:0], item_weight[47:16]
	logic [0:0]           s_axis_tuser;   // action[0]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;   // ranked_id[15:0], rank[21:16], hit_count[29:22]
	logic                 m_axis_tlast;   // is_last
	logic [M_TUSER_W-1:0] m_axis_tuser;   // is_empty[0], overflowed[1]
	logic                 cfg_we;
	logic [LIMIT_W-1:0]   cfg_data;

	// shadow of the ranked table
	logic [ID_FIELD_W-1:0]     tbl_id[DEPTH];
	logic [COUNT_W-1:0]        tbl_count[DEPTH];
	logic [WEIGHT_FIELD_W-1:0] tbl_weight[DEPTH];
	int                        tbl_used;
	logic                      dropped;
	logic [LIMIT_W-1:0]        limit_reg;

	rank_beat_t expected_beats[$];
	rank_beat_t got_beat;
	rank_beat_t want_beat;
	logic [ID_FIELD_W-1:0] id_pool[POOL_SIZE];
	int  fail_count;
	int  quiet_cycles;
	int  stall_left;
	bit  idling_on;

	ranked_hit_count_table_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------- table shadow ----------------

	function automatic int find_entry(input logic [ID_FIELD_W-1:0] id);
		for (int k = 0; k < tbl_used; k++)
			if (tbl_id[k] == id)
				return k;
		return -1;
	endfunction

	// insert ahead of the first entry that does not beat the new one
	function automatic void place_entry(input logic [ID_FIELD_W-1:0] id,
			input logic [COUNT_W-1:0] cnt, input logic [WEIGHT_FIELD_W-1:0] w);
		int pos;
		pos = 0;
		while (pos < tbl_used && (tbl_count[pos] > cnt ||
				(tbl_count[pos] == cnt && tbl_weight[pos] > w)))
			pos++;
		for (int k = tbl_used; k > pos; k--) begin
			tbl_id[k] = tbl_id[k-1];
			tbl_count[k] = tbl_count[k-1];
			tbl_weight[k] = tbl_weight[k-1];
		end
		tbl_id[pos] = id;
		tbl_count[pos] = cnt;
		tbl_weight[pos] = w;
		tbl_used++;
	endfunction

	function automatic void record_hit(input logic [ID_FIELD_W-1:0] id,
			input logic [WEIGHT_FIELD_W-1:0] w);
		int pos;
		logic [COUNT_W-1:0] cnt;
		logic [WEIGHT_FIELD_W-1:0] old_w;
		pos = find_entry(id);
		if (pos >= 0) begin
			cnt = tbl_count[pos];
			old_w = tbl_weight[pos];
			if (cnt != COUNT_MAX)
				cnt++;
			// pull the entry out, then re-rank it
			for (int k = pos; k + 1 < tbl_used; k++) begin
				tbl_id[k] = tbl_id[k+1];
				tbl_count[k] = tbl_count[k+1];
				tbl_weight[k] = tbl_weight[k+1];
			end
			tbl_used--;
			place_entry(id, cnt, old_w);
		end else if (tbl_used >= DEPTH) begin
			dropped = 1'b1;
		end else begin
			place_entry(id, COUNT_W'(1), w);
		end
	endfunction

	// queue the beats of one report
	function automatic void predict_report();
		int lim;
		int n;
		rank_beat_t b;
		b = '0;
		if (tbl_used == 0) begin
			b.is_empty = 1'b1;
			expected_beats.push_back(b);
			return;
		end
		lim = int'(limit_reg);
		if (lim < 1)
			lim = 1;
		if (lim > MAX_REPORT)
			lim = MAX_REPORT;
		n = (tbl_used < lim) ? tbl_used : lim;
		for (int k = 0; k < n; k++) begin
			b.ranked_id = tbl_id[k];
			b.rank = RANK_W'(k);
			b.hit_count = tbl_count[k];
			b.is_last = (k + 1 == n);
			b.is_empty = 1'b0;
			b.overflowed = dropped;
			expected_beats.push_back(b);
		end
	endfunction

	// ---------------- stimulus helpers ----------------

	// one input beat, driven at the falling edge; valid stays high afterwards
	task automatic send_item(input logic act, input logic [ID_FIELD_W-1:0] id,
			input logic [WEIGHT_FIELD_W-1:0] w);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {w, id};
		s_axis_tuser <= act;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (act == ACT_HIT)
			record_hit(id, w);
		else
			predict_report();
		@(negedge clk);
	endtask

	// hold the sender until all queued beats are out
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() > 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// register write while idle; hits leave no beat, so let them finish first
	task automatic set_report_limit(input logic [LIMIT_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_reg = value;
	endtask

	function automatic logic [WEIGHT_FIELD_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'h4000_0000;
			3: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [ID_FIELD_W-1:0] fresh_id();
		logic [ID_FIELD_W-1:0] id;
		do
			id = ID_FIELD_W'($urandom_range(0, 65535));
		while (find_entry(id) >= 0);
		return id;
	endfunction

	// ---------------- tests ----------------

	task automatic test_empty_report();
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_REPORT, '1, '1);
	endtask

	// extremes of id and weight, ties on count and weight
	task automatic test_ordering_and_ties();
		send_item(ACT_HIT, 16'h0000, 32'h0000_0000);
		send_item(ACT_HIT, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(ACT_HIT, 16'h1234, 32'h8000_0000);
		// equal count and weight: newcomer goes first
		send_item(ACT_HIT, 16'h4321, 32'h8000_0000);
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_HIT, 16'h1234, 32'h0000_0001);
		send_item(ACT_HIT, 16'h4321, 32'hFFFF_FFFF);
		send_item(ACT_HIT, 16'h0000, 32'h5555_5555);
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_HIT, 16'h0000, 32'hAAAA_AAAA);
		send_item(ACT_REPORT, 16'hA5A5, 32'h5A5A_5A5A);
	endtask

	// limits at and past both ends
	task automatic test_limit_extremes();
		set_report_limit(7'd0);
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd1);
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd2);
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd65);
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd127);
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd64);
		send_item(ACT_REPORT, '0, '0);
	endtask

	// mostly hits on a fixed id pool, some random ids and reports
	task automatic test_random_traffic(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 19) == 0)
				drain_results();
			if ($urandom_range(0, 7) == 0)
				send_item(ACT_REPORT, ID_FIELD_W'($urandom()), $urandom());
			else if ($urandom_range(0, 7) == 0)
				send_item(ACT_HIT, ID_FIELD_W'($urandom()), pick_weight());
			else
				send_item(ACT_HIT, id_pool[$urandom_range(0, POOL_SIZE - 1)],
					pick_weight());
		end
	endtask

	// fill every slot, then new ids get dropped and flagged
	task automatic test_full_table();
		while (tbl_used < DEPTH)
			send_item(ACT_HIT, fresh_id(), pick_weight());
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_HIT, fresh_id(), pick_weight());
		send_item(ACT_HIT, fresh_id(), pick_weight());
		send_item(ACT_HIT, tbl_id[DEPTH-1], pick_weight());
		send_item(ACT_REPORT, '0, '0);
		set_report_limit(7'd127);
		send_item(ACT_REPORT, '0, '0);
	endtask

	// bump two ids in turn to equal counts, then each once more
	task automatic test_repeat_bumps();
		set_report_limit(7'd3);
		repeat (4) begin
			send_item(ACT_HIT, 16'h1234, pick_weight());
			send_item(ACT_HIT, 16'h4321, pick_weight());
		end
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_HIT, 16'h1234, '0);
		send_item(ACT_REPORT, '0, '0);
		send_item(ACT_HIT, 16'h4321, '1);
		send_item(ACT_REPORT, '0, '0);
	endtask

	// ---------------- output side ----------------

	// ready with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_beat.ranked_id = m_axis_tdata[15:0];
			got_beat.rank = m_axis_tdata[21:16];
			got_beat.hit_count = m_axis_tdata[29:22];
			got_beat.is_last = m_axis_tlast;
			got_beat.is_empty = m_axis_tuser[0];
			got_beat.overflowed = m_axis_tuser[1];
			if (expected_beats.size() == 0) begin
				$error("result beat with none expected: ranked_id %0d rank %0d",
					got_beat.ranked_id, got_beat.rank);
				fail_count++;
			end else begin
				want_beat = expected_beats.pop_front();
				check_field("ranked_id", want_beat.ranked_id, got_beat.ranked_id);
				check_field("rank", want_beat.rank, got_beat.rank);
				check_field("hit_count", want_beat.hit_count, got_beat.hit_count);
				check_field("is_last", want_beat.is_last, got_beat.is_last);
				check_field("is_empty", want_beat.is_empty, got_beat.is_empty);
				check_field("overflowed", want_beat.overflowed, got_beat.overflowed);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		fail_count = 0;
		quiet_cycles = 0;
		stall_left = 0;
		idling_on = 1'b1;
		tbl_used = 0;
		dropped = 1'b0;
		limit_reg = LIMIT_W'(LIMIT_RESET);
		for (int k = 0; k < POOL_SIZE; k++)
			id_pool[k] = ID_FIELD_W'($urandom_range(0, 65535));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_report();
		test_ordering_and_ties();
		test_limit_extremes();
		set_report_limit(LIMIT_W'($urandom_range(0, 127)));
		test_random_traffic(20);
		set_report_limit(7'd5);
		test_random_traffic(20);
		set_report_limit(LIMIT_W'($urandom_range(0, 127)));
		test_random_traffic(20);
		test_full_table();
		test_repeat_bumps();
		set_report_limit(LIMIT_W'($urandom_range(1, 64)));
		test_random_traffic(25);
		// back-to-back on both sides for the closing stretch
		idling_on = 1'b0;
		set_report_limit(7'd64);
		test_random_traffic(20);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
